@@ rtl/core/fwsk_pkg.sv @@
package fwsk_pkg;

   // register indexes on the csr port
   localparam logic [7:0] CSR_HALF_LENGTH  = 8'd0;
   localparam logic [7:0] CSR_HALF_WIDTH   = 8'd1;
   localparam logic [7:0] CSR_WHEEL_RADIUS = 8'd2;
   localparam logic [7:0] CSR_MIN_SPEED    = 8'd3;

   localparam logic [14:0] HALF_LENGTH_RST  = 15'd3072;
   localparam logic [14:0] HALF_WIDTH_RST   = 15'd2048;
   localparam logic [14:0] WHEEL_RADIUS_RST = 15'd614;
   localparam logic [15:0] MIN_SPEED_RST    = 16'd51;

   localparam int          CORDIC_STEPS = 18;
   localparam logic [4:0]  CORDIC_LAST  = 5'd17;
   localparam logic [17:0] GAIN_Q16     = 18'd39797;
   localparam logic [15:0] ANGLE_LIMIT  = 16'd12868;

   localparam int         SPIN_W     = 24;
   localparam int         DIVIDEND_W = 31;
   localparam logic [3:0] DIV_LAST   = 4'd11;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_MUL_HL  = 10'b0000000010,
      ST_MUL_HW  = 10'b0000000100,
      ST_LOAD    = 10'b0000001000,
      ST_CORDIC  = 10'b0000010000,
      ST_GAIN_LO = 10'b0000100000,
      ST_GAIN_HI = 10'b0001000000,
      ST_DECIDE  = 10'b0010000000,
      ST_DIVIDE  = 10'b0100000000,
      ST_FINISH  = 10'b1000000000
   } state_type;

   // atan(2^-k) in 2^-20 rad
   function automatic logic [19:0] atan_q20(input logic [4:0] k);
      case (k)
         5'd0:    atan_q20 = 20'd823550;
         5'd1:    atan_q20 = 20'd486170;
         5'd2:    atan_q20 = 20'd256879;
         5'd3:    atan_q20 = 20'd130396;
         5'd4:    atan_q20 = 20'd65451;
         5'd5:    atan_q20 = 20'd32757;
         5'd6:    atan_q20 = 20'd16383;
         5'd7:    atan_q20 = 20'd8192;
         5'd8:    atan_q20 = 20'd4096;
         5'd9:    atan_q20 = 20'd2048;
         5'd10:   atan_q20 = 20'd1024;
         5'd11:   atan_q20 = 20'd512;
         5'd12:   atan_q20 = 20'd256;
         5'd13:   atan_q20 = 20'd128;
         5'd14:   atan_q20 = 20'd64;
         5'd15:   atan_q20 = 20'd32;
         5'd16:   atan_q20 = 20'd16;
         5'd17:   atan_q20 = 20'd8;
         default: atan_q20 = 20'd0;
      endcase
   endfunction

endpackage

@@ rtl/core/fwsk_div.sv @@
module fwsk_div import fwsk_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [14:0]           divisor,
   output div_status_type        status,
   output logic [SPIN_W-2:0]     quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        sat_ff, sat_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [14:0] rem_ff, rem_in;
   logic [14:0] den_ff, den_in;
   logic [23:0] num_ff, num_in;
   logic [23:0] quo_ff, quo_in;

   logic [15:0] t1, t2;
   logic        g1, g2;
   logic [14:0] r1, r2;

   // two restoring steps per cycle
   always_comb begin
      t1 = {rem_ff, num_ff[23]};
      g1 = t1 >= {1'b0, den_ff};
      r1 = g1 ? 15'(t1 - {1'b0, den_ff}) : t1[14:0];
      t2 = {r1, num_ff[22]};
      g2 = t2 >= {1'b0, den_ff};
      r2 = g2 ? 15'(t2 - {1'b0, den_ff}) : t2[14:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (start) begin
         // quotient would not fit below 2^23, zero divisor included
         sat_in  = {7'b0, dividend} >= {divisor, 23'b0};
         rem_in  = {8'b0, dividend[30:24]};
         num_in  = dividend[23:0];
         den_in  = divisor;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = r2;
         num_in = {num_ff[21:0], 2'b00};
         quo_in = {quo_ff[21:0], g1, g2};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sat_ff <= sat_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = sat_ff ? '1 : quo_ff[SPIN_W-2:0];

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("divider did not start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !sat_ff |-> rem_ff < den_ff) else $error("remainder out of range");

endmodule

@@ rtl/core/four_wheel_steer_kinematics.sv @@
// Four-wheel independent steering inverse kinematics. A req beat carries a body
// velocity command (forward and lateral in 2^-10 m/s, yaw rate in 2^-12 rad/s);
// the rsp beat gives each wheel a steering angle in 2^-13 rad, within +-pi/2, and
// a signed spin speed in 2^-8 rad/s, saturated to +-8388607. Wheels whose
// contact speed is at or below the minimum speed register keep their last angle
// and report zero spin. The four wheels are handled one after another, each going
// through load, CORDIC, gain multiply, decide and, if it moves, the divider; all
// four wheels share the one CORDIC datapath and the radix-4 divider, which a held
// wheel skips after its decide step. req_ready is high only while the
// sequencer is idle; a finished rsp beat waits in its own register, so the next
// req beat can be taken while it is pending. csr writes are taken at any time
// but are meant for idle periods; indexes beyond the four registers are ignored.
module four_wheel_steer_kinematics import fwsk_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_vel_forward,
   input  logic signed [15:0] req_vel_lateral,
   input  logic signed [15:0] req_yaw_rate,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [14:0] rsp_angle_front_left,
   output logic signed [14:0] rsp_angle_front_right,
   output logic signed [14:0] rsp_angle_rear_left,
   output logic signed [14:0] rsp_angle_rear_right,
   output logic signed [23:0] rsp_spin_front_left,
   output logic signed [23:0] rsp_spin_front_right,
   output logic signed [23:0] rsp_spin_rear_left,
   output logic signed [23:0] rsp_spin_rear_right,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   // configuration
   logic [14:0] hl_ff, hw_ff, wr_ff;
   logic [15:0] thr_ff;

   state_type state_ff, state_in;

   // latched command and yaw products
   logic signed [15:0] vx_ff, vx_in, vy_ff, vy_in, w_ff, w_in;
   logic signed [31:0] whl_ff, whl_in, whw_ff, whw_in;

   // per-wheel datapath
   logic [1:0]         idx_ff, idx_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic signed [35:0] x_ff, x_in, y_ff, y_in;
   logic signed [21:0] z_ff, z_in;
   logic               turned_ff, turned_in;
   logic [32:0]        plo_ff, plo_in;
   logic [34:0]        mag_ff, mag_in;
   logic signed [14:0] ang_cur_ff, ang_cur_in;

   // per-wheel results and held angles
   logic signed [14:0] held_ff [4];
   logic signed [14:0] held_in [4];
   logic signed [14:0] ang_res_ff [4];
   logic signed [14:0] ang_res_in [4];
   logic signed [23:0] spin_res_ff [4];
   logic signed [23:0] spin_res_in [4];

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [14:0] rsp_ang_ff [4];
   logic signed [14:0] rsp_ang_in [4];
   logic signed [23:0] rsp_spin_ff [4];
   logic signed [23:0] rsp_spin_in [4];

   // shared multiplier
   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] prod;

   // divider
   logic                 div_start;
   div_status_type       div_stat;
   logic [SPIN_W-2:0]    div_q;

   // scratch
   logic signed [35:0] vx36, vy36, whl36, whw36, x_raw, y_raw, xs, ys;
   logic [50:0]        mag_sum;
   logic [34:0]        thr_cmp;
   logic signed [21:0] atan_s;

   function automatic logic signed [14:0] round_angle(input logic signed [21:0] z);
      logic [21:0] zm;
      logic [15:0] r;
      zm = z[21] ? 22'(-z) : z;
      r  = 16'((zm + 22'd64) >> 7);
      if (r > ANGLE_LIMIT) r = ANGLE_LIMIT;
      round_angle = z[21] ? 15'(-r) : 15'(r);
   endfunction

   fwsk_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_ff[34:4]),
      .divisor  (wr_ff),
      .status   (div_stat),
      .quotient (div_q)
   );

   assign prod = mul_a * mul_b;

   always_comb begin
      vx36    = $signed({{6{vx_ff[15]}}, vx_ff, 14'b0});
      vy36    = $signed({{6{vy_ff[15]}}, vy_ff, 14'b0});
      whl36   = $signed({{4{whl_ff[31]}}, whl_ff});
      whw36   = $signed({{4{whw_ff[31]}}, whw_ff});
      // vix = vx - w*y, viy = vy + w*x; left wheels at +y, front at +x
      x_raw   = idx_ff[0] ? vx36 + whw36 : vx36 - whw36;
      y_raw   = idx_ff[1] ? vy36 - whl36 : vy36 + whl36;
      xs      = x_ff >>> cnt_ff;
      ys      = y_ff >>> cnt_ff;
      atan_s  = $signed({2'b00, atan_q20(cnt_ff)});
      mag_sum = {1'b0, prod[32:0], 17'b0} + {18'b0, plo_ff};
      thr_cmp = {5'b0, thr_ff, 14'b0};
   end

   always_comb begin
      state_in     = state_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      w_in         = w_ff;
      whl_in       = whl_ff;
      whw_in       = whw_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      turned_in    = turned_ff;
      plo_in       = plo_ff;
      mag_in       = mag_ff;
      ang_cur_in   = ang_cur_ff;
      held_in      = held_ff;
      ang_res_in   = ang_res_ff;
      spin_res_in  = spin_res_ff;
      rsp_ang_in   = rsp_ang_ff;
      rsp_spin_in  = rsp_spin_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               vx_in    = req_vel_forward;
               vy_in    = req_vel_lateral;
               w_in     = req_yaw_rate;
               state_in = ST_MUL_HL;
            end
         end
         ST_MUL_HL: begin
            mul_a    = {{2{w_ff[15]}}, w_ff};
            mul_b    = {3'b0, hl_ff};
            whl_in   = prod[31:0];
            state_in = ST_MUL_HW;
         end
         ST_MUL_HW: begin
            mul_a    = {{2{w_ff[15]}}, w_ff};
            mul_b    = {3'b0, hw_ff};
            whw_in   = prod[31:0];
            idx_in   = 2'd0;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // backward-pointing vector: turn by pi, spin gets negated
            turned_in = x_raw[35];
            x_in      = x_raw[35] ? -x_raw : x_raw;
            y_in      = x_raw[35] ? -y_raw : y_raw;
            z_in      = '0;
            cnt_in    = '0;
            state_in  = ST_CORDIC;
         end
         ST_CORDIC: begin
            if (!y_ff[35]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_s;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_s;
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == CORDIC_LAST) state_in = ST_GAIN_LO;
         end
         ST_GAIN_LO: begin
            mul_a    = {1'b0, x_ff[16:0]};
            mul_b    = GAIN_Q16;
            plo_in   = prod[32:0];
            state_in = ST_GAIN_HI;
         end
         ST_GAIN_HI: begin
            mul_a    = {1'b0, x_ff[33:17]};
            mul_b    = GAIN_Q16;
            mag_in   = mag_sum[50:16];
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (mag_ff > thr_cmp) begin
               ang_cur_in = round_angle(z_ff);
               div_start  = 1'b1;
               state_in   = ST_DIVIDE;
            end else begin
               // too slow to steer: keep angle, no spin
               ang_res_in[idx_ff]  = held_ff[idx_ff];
               spin_res_in[idx_ff] = '0;
               idx_in   = idx_ff + 2'd1;
               state_in = (idx_ff == 2'd3) ? ST_FINISH : ST_LOAD;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               ang_res_in[idx_ff]  = ang_cur_ff;
               held_in[idx_ff]     = ang_cur_ff;
               spin_res_in[idx_ff] = turned_ff ? 24'(-{1'b0, div_q}) : {1'b0, div_q};
               idx_in   = idx_ff + 2'd1;
               state_in = (idx_ff == 2'd3) ? ST_FINISH : ST_LOAD;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_ang_in   = ang_res_ff;
               rsp_spin_in  = spin_res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         held_ff      <= '{default: '0};
         hl_ff        <= HALF_LENGTH_RST;
         hw_ff        <= HALF_WIDTH_RST;
         wr_ff        <= WHEEL_RADIUS_RST;
         thr_ff       <= MIN_SPEED_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_HALF_LENGTH:  hl_ff  <= csr_wdata[14:0];
               CSR_HALF_WIDTH:   hw_ff  <= csr_wdata[14:0];
               CSR_WHEEL_RADIUS: wr_ff  <= csr_wdata[14:0];
               CSR_MIN_SPEED:    thr_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      w_ff        <= w_in;
      whl_ff      <= whl_in;
      whw_ff      <= whw_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      turned_ff   <= turned_in;
      plo_ff      <= plo_in;
      mag_ff      <= mag_in;
      ang_cur_ff  <= ang_cur_in;
      ang_res_ff  <= ang_res_in;
      spin_res_ff <= spin_res_in;
      rsp_ang_ff  <= rsp_ang_in;
      rsp_spin_ff <= rsp_spin_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   assign rsp_angle_front_left  = rsp_ang_ff[0];
   assign rsp_angle_front_right = rsp_ang_ff[1];
   assign rsp_angle_rear_left   = rsp_ang_ff[2];
   assign rsp_angle_rear_right  = rsp_ang_ff[3];
   assign rsp_spin_front_left   = rsp_spin_ff[0];
   assign rsp_spin_front_right  = rsp_spin_ff[1];
   assign rsp_spin_rear_left    = rsp_spin_ff[2];
   assign rsp_spin_rear_right   = rsp_spin_ff[3];

   // vectoring always runs in the right half plane
   a_x_positive: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CORDIC |-> !x_ff[35]) else $error("cordic x went negative");
   a_div_alive: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> div_stat.busy || div_stat.done)
      else $error("waiting on an idle divider");
   a_finish_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff)
      else $error("finished item lost its rsp beat");
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> ang_cur_ff <= 15'sd12868 && ang_cur_ff >= -15'sd12868)
      else $error("steering angle out of range");

endmodule
